FILE: rtl/hta_pkg.sv
// Shared types and constants of the handle table allocator.
package hta_pkg;

    localparam int SLOT_BITS  = 8;
    localparam int SLOTS      = 1 << SLOT_BITS;
    localparam int COUNT_W    = SLOT_BITS + 1;
    localparam int INDEX_BITS = 24;
    localparam int HARBOR_W   = 8;
    localparam int HANDLE_W   = 32;
    localparam int CTX_W      = 16;
    localparam int STATUS_W   = 2;

    localparam logic [SLOT_BITS-1:0] INIT_MASK = SLOT_BITS'(3);
    localparam logic [SLOT_BITS-1:0] FULL_MASK = {SLOT_BITS{1'b1}};

    localparam logic FUNC_REGISTER = 1'b0;
    localparam logic FUNC_LOOKUP   = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [CTX_W-1:0]    context_id;
    } hta_entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // capture the accepted input item
        logic lk_read;      // read the slot that the lookup handle picks
        logic emit_lookup;  // send the lookup result
        logic probe_start;  // start probing at the running index
        logic probe_step;   // advance to the next candidate
        logic probe_take;   // claim the current slot and send the handle
        logic emit_full;    // send the table full result
        logic grow_start;   // reset the move sweep
        logic grow_step;    // read one old slot for the move sweep
        logic grow_end;     // double the table size
    } hta_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic func;
        logic slot_free;
        logic table_full;
        logic at_limit;
        logic out_free;
        logic grow_last;
    } hta_stat_t;

endpackage

FILE: rtl/hta_ctrl.sv
// Controller state machine of the handle table allocator.
module hta_ctrl
    import hta_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  hta_stat_t stat,
    output hta_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LK_OUT,
        ST_PROBE,
        ST_FULL_OUT,
        ST_GROW,
        ST_GROW_TAIL
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (stat.func == FUNC_LOOKUP) begin
                    cmd.lk_read = 1'b1;
                    state_next  = ST_LK_OUT;
                end else if (!stat.table_full) begin
                    cmd.probe_start = 1'b1;
                    state_next      = ST_PROBE;
                end else if (stat.at_limit) begin
                    state_next = ST_FULL_OUT;
                end else begin
                    cmd.grow_start = 1'b1;
                    state_next     = ST_GROW;
                end
            end
            ST_LK_OUT: begin
                if (stat.out_free) begin
                    cmd.emit_lookup = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_PROBE: begin
                priority if (!stat.slot_free) begin
                    cmd.probe_step = 1'b1;
                end else if (stat.out_free) begin
                    cmd.probe_take = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FULL_OUT: begin
                if (stat.out_free) begin
                    cmd.emit_full = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_GROW: begin
                cmd.grow_step = 1'b1;
                if (stat.grow_last) begin
                    state_next = ST_GROW_TAIL;
                end
            end
            ST_GROW_TAIL: begin
                cmd.grow_end    = 1'b1;
                cmd.probe_start = 1'b1;
                state_next      = ST_PROBE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/hta_datapath.sv
// Datapath of the handle table allocator: slot memory, valid bits, indexes, output register.
module hta_datapath
    import hta_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr,
    input  logic [HARBOR_W-1:0]   cfg_data,
    input  logic                  s_func,
    input  logic [CTX_W-1:0]      s_context_id,
    input  logic [HANDLE_W-1:0]   s_lookup_handle,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [HANDLE_W-1:0]   m_result_handle,
    output logic [CTX_W-1:0]      m_result_context,
    output logic [STATUS_W-1:0]   m_status,
    input  hta_cmd_t              cmd,
    output hta_stat_t             stat
);

    hta_entry_t mem [SLOTS];

    logic [SLOTS-1:0]      valid_reg;
    logic [HARBOR_W-1:0]   harbor_reg;
    logic                  func_reg;
    logic [CTX_W-1:0]      ctx_reg;
    logic [HANDLE_W-1:0]   look_reg;
    logic [SLOT_BITS-1:0]  mask_reg;
    logic [INDEX_BITS-1:0] next_index_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [INDEX_BITS-1:0] probe_reg;
    logic [SLOT_BITS-1:0]  gidx_reg;
    logic                  move_pending_reg;
    logic [SLOT_BITS-1:0]  move_slot_reg;
    hta_entry_t            rd_reg;
    logic                  m_valid_reg;
    logic [HANDLE_W-1:0]   m_handle_reg;
    logic [CTX_W-1:0]      m_ctx_reg;
    logic [STATUS_W-1:0]   m_status_reg;

    logic [SLOT_BITS-1:0] look_slot;
    logic [SLOT_BITS-1:0] probe_slot;
    logic [SLOT_BITS-1:0] old_bit;
    logic [SLOT_BITS-1:0] move_dst;
    logic                 move_up;
    logic                 lk_hit;
    logic [HANDLE_W-1:0]  new_handle;
    logic                 rd_en;
    logic [SLOT_BITS-1:0] rd_addr;
    logic                 wr_en;
    logic [SLOT_BITS-1:0] wr_addr;
    hta_entry_t           wr_data;
    logic                 out_free;

    assign look_slot  = look_reg[SLOT_BITS-1:0] & mask_reg;
    assign probe_slot = probe_reg[SLOT_BITS-1:0] & mask_reg;
    // During a sweep the old size is a single bit: the handle bit that decides the move.
    assign old_bit    = mask_reg + SLOT_BITS'(1);
    assign move_dst   = move_slot_reg | old_bit;
    assign move_up    = move_pending_reg && valid_reg[move_slot_reg]
                        && (|(rd_reg.handle[SLOT_BITS-1:0] & old_bit));
    assign lk_hit     = valid_reg[look_slot] && (rd_reg.handle == look_reg);
    assign new_handle = {harbor_reg, probe_reg};
    assign out_free   = !m_valid_reg || m_ready;

    assign rd_en   = cmd.lk_read || cmd.grow_step;
    assign rd_addr = cmd.lk_read ? look_slot : gidx_reg;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = probe_slot;
        wr_data = '{handle: new_handle, context_id: ctx_reg};
        if (cmd.probe_take) begin
            wr_en = 1'b1;
        end else if (move_up) begin
            wr_en   = 1'b1;
            wr_addr = move_dst;
            wr_data = rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign stat.func       = func_reg;
    assign stat.slot_free  = !valid_reg[probe_slot];
    assign stat.table_full = (count_reg == ({1'b0, mask_reg} + COUNT_W'(1)));
    assign stat.at_limit   = (mask_reg == FULL_MASK);
    assign stat.out_free   = out_free;
    assign stat.grow_last  = (gidx_reg == mask_reg);

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= s_func;
            ctx_reg  <= s_context_id;
            look_reg <= s_lookup_handle;
        end
        if (cmd.probe_start) begin
            probe_reg <= next_index_reg;
        end else if (cmd.probe_step) begin
            probe_reg <= probe_reg + INDEX_BITS'(1);
        end
        if (cmd.grow_step) begin
            move_slot_reg <= gidx_reg;
        end
        if (cmd.emit_lookup) begin
            m_handle_reg <= look_reg;
            m_ctx_reg    <= lk_hit ? rd_reg.context_id : '0;
            m_status_reg <= lk_hit ? STATUS_OK : STATUS_NOT_FOUND;
        end else if (cmd.probe_take) begin
            m_handle_reg <= new_handle;
            m_ctx_reg    <= ctx_reg;
            m_status_reg <= STATUS_OK;
        end else if (cmd.emit_full) begin
            m_handle_reg <= '0;
            m_ctx_reg    <= ctx_reg;
            m_status_reg <= STATUS_FULL;
        end
    end

    // Control and table state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg        <= '0;
            harbor_reg       <= '0;
            mask_reg         <= INIT_MASK;
            next_index_reg   <= '0;
            count_reg        <= '0;
            gidx_reg         <= '0;
            move_pending_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr) begin
                harbor_reg <= cfg_data;
            end
            if (cmd.probe_take) begin
                valid_reg[probe_slot] <= 1'b1;
                next_index_reg        <= probe_reg + INDEX_BITS'(1);
                count_reg             <= count_reg + COUNT_W'(1);
            end else if (move_up) begin
                valid_reg[move_dst]      <= 1'b1;
                valid_reg[move_slot_reg] <= 1'b0;
            end
            if (cmd.grow_start) begin
                gidx_reg <= '0;
            end else if (cmd.grow_step) begin
                gidx_reg <= gidx_reg + SLOT_BITS'(1);
            end
            move_pending_reg <= cmd.grow_step;
            if (cmd.grow_end) begin
                mask_reg <= {mask_reg[SLOT_BITS-2:0], 1'b1};
            end
            if (cmd.emit_lookup || cmd.probe_take || cmd.emit_full) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_handle  = m_handle_reg;
    assign m_result_context = m_ctx_reg;
    assign m_status         = m_status_reg;

endmodule

FILE: rtl/handle_table_allocator.sv
// Top level of the handle table allocator: controller and datapath.
//
// The block issues handles for context identifiers and resolves them again.
// Input transfers on the s_ channel carry s_func (0 register, 1 look up),
// s_context_id and s_lookup_handle; every input transfer yields exactly one
// result transfer on the m_ channel with a handle, a context and a status.
// The cfg_ channel writes the eight bit node number that forms the top bits
// of each issued handle; it is always ready. The user must write it only
// while idle; the block itself does not enforce this. One item is worked on
// at a time. A lookup decodes and issues the registered read of the slot
// memory, then compares and loads the output register. A registration probes
// one slot per cycle from the running index, passing each occupied slot.
// When every slot is in use the table doubles below its largest size, which
// sweeps the old slots through the single read port of the slot memory
// before probing starts again; at the largest size a full status is sent.
// The input is ready again in the cycle after a result is loaded, so a new
// item is taken only once the last one's result is loaded. The result sits
// in an output register, so a new item is taken while a finished result
// still waits; a stalled receiver holds the block only when the next result
// is ready to be written. Reset clears all valid bits at once, sets the
// table to four slots and needs no clearing pass.
module handle_table_allocator
    import hta_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [HARBOR_W-1:0] cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [CTX_W-1:0]    s_context_id,
    input  logic [HANDLE_W-1:0] s_lookup_handle,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [HANDLE_W-1:0] m_result_handle,
    output logic [CTX_W-1:0]    m_result_context,
    output logic [STATUS_W-1:0] m_status
);

    hta_cmd_t  cmd;
    hta_stat_t stat;

    // The node number register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    hta_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hta_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr           (cfg_valid),
        .cfg_data         (cfg_data),
        .s_func           (s_func),
        .s_context_id     (s_context_id),
        .s_lookup_handle  (s_lookup_handle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_handle  (m_result_handle),
        .m_result_context (m_result_context),
        .m_status         (m_status),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule

FILE: tb/tb_handle_table_allocator.sv
`timescale 1ns / 1ps
// Self-checking testbench for the handle table allocator with a built-in table predictor.
module tb_handle_table_allocator;
    import hta_pkg::*;

    // Kinds of queued input items. Lookup targets that depend on earlier
    // registrations are chosen only when the item is put on the bus, so they are
    // drawn from handles the predictor has already issued, or use the item's own handle while none is issued.
    typedef enum logic [1:0] {
        ITEM_REGISTER,
        ITEM_LOOKUP_FIXED,
        ITEM_LOOKUP_ISSUED,
        ITEM_LOOKUP_FLIPPED
    } item_kind_t;

    typedef struct {
        item_kind_t          kind;
        logic [CTX_W-1:0]    ctx;
        logic [HANDLE_W-1:0] look;
    } pending_item_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [CTX_W-1:0]    ctx;
        logic [STATUS_W-1:0] status;
    } table_reply_t;

    logic                aclk             = 1'b0;
    logic                aresetn          = 1'b0;
    logic                cfg_valid        = 1'b0;
    logic                cfg_ready;
    logic [HARBOR_W-1:0] cfg_data         = '0;
    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic                s_func           = FUNC_REGISTER;
    logic [CTX_W-1:0]    s_context_id     = '0;
    logic [HANDLE_W-1:0] s_lookup_handle  = '0;
    logic                m_valid;
    logic                m_ready          = 1'b0;
    logic [HANDLE_W-1:0] m_result_handle;
    logic [CTX_W-1:0]    m_result_context;
    logic [STATUS_W-1:0] m_status;

    // Shadow copy of the slot table and its bookkeeping.
    bit                  occupied     [SLOTS];
    logic [HANDLE_W-1:0] stored_handle[SLOTS];
    logic [CTX_W-1:0]    stored_ctx   [SLOTS];
    int unsigned         tbl_size     = 4;
    logic [INDEX_BITS-1:0] run_index  = '0;
    logic [HARBOR_W-1:0] node_number  = '0;

    pending_item_t       pending_items[$];
    table_reply_t        expected_replies[$];
    logic [HANDLE_W-1:0] issued_handles[$];

    // Idle and stall rates in percent; changed only between phases.
    int unsigned         send_idle_pct = 0;
    int unsigned         stall_pct     = 0;
    int unsigned         fail_count    = 0;

    // Long receiver hold-off, requested once by the stimulus sequence.
    bit                  hold_request  = 1'b0;
    bit                  hold_started  = 1'b0;
    int unsigned         hold_left     = 0;

    handle_table_allocator dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_context_id     (s_context_id),
        .s_lookup_handle  (s_lookup_handle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_handle  (m_result_handle),
        .m_result_context (m_result_context),
        .m_status         (m_status)
    );

    always #5 aclk = ~aclk;

    // Doubles the shadow table. Every slot below the old size is in use, so
    // each entry whose handle has the old size bit set moves up by that size.
    function automatic void double_table();
        int unsigned old_size;
        old_size = tbl_size;
        for (int unsigned s = old_size; s < 2 * old_size && s < SLOTS; s++) begin
            occupied[s] = 1'b0;
        end
        for (int unsigned s = 0; s < old_size; s++) begin
            if (occupied[s] && (stored_handle[s] & HANDLE_W'(old_size)) != '0
                && s + old_size < SLOTS) begin
                occupied[s + old_size]      = 1'b1;
                stored_handle[s + old_size] = stored_handle[s];
                stored_ctx[s + old_size]    = stored_ctx[s];
                occupied[s]                 = 1'b0;
            end
        end
        tbl_size = 2 * old_size;
    endfunction

    // Works out the reply to one accepted input transfer and updates the
    // shadow table as the block would.
    function automatic table_reply_t resolve_item(input logic func,
                                                  input logic [CTX_W-1:0] ctx,
                                                  input logic [HANDLE_W-1:0] look);
        table_reply_t          reply;
        int unsigned           s;
        logic [INDEX_BITS-1:0] cand;
        logic [HANDLE_W-1:0]   h;
        bit                    done;
        if (func == FUNC_LOOKUP) begin
            s = int'(look & HANDLE_W'(tbl_size - 1));
            reply.handle = look;
            if (occupied[s] && stored_handle[s] == look) begin
                reply.ctx    = stored_ctx[s];
                reply.status = STATUS_OK;
            end else begin
                reply.ctx    = '0;
                reply.status = STATUS_NOT_FOUND;
            end
            return reply;
        end
        done = 1'b0;
        while (!done) begin
            for (int unsigned i = 0; i < tbl_size && !done; i++) begin
                cand = run_index + INDEX_BITS'(i);
                s    = int'(cand & INDEX_BITS'(tbl_size - 1));
                if (!occupied[s]) begin
                    h = (HANDLE_W'(node_number) << INDEX_BITS) | HANDLE_W'(cand);
                    occupied[s]      = 1'b1;
                    stored_handle[s] = h;
                    stored_ctx[s]    = ctx;
                    run_index        = cand + 1'b1;
                    issued_handles.push_back(h);
                    reply.handle = h;
                    reply.ctx    = ctx;
                    reply.status = STATUS_OK;
                    done = 1'b1;
                end
            end
            if (!done) begin
                if (2 * tbl_size > SLOTS) begin
                    reply.handle = '0;
                    reply.ctx    = ctx;
                    reply.status = STATUS_FULL;
                    done = 1'b1;
                end else begin
                    double_table();
                end
            end
        end
        return reply;
    endfunction

    // Chooses the handle that a lookup item carries when it goes on the bus.
    function automatic logic [HANDLE_W-1:0] lookup_target(input pending_item_t it);
        logic [HANDLE_W-1:0] h;
        if (it.kind == ITEM_LOOKUP_FIXED || issued_handles.size() == 0) begin
            return it.look;
        end
        h = issued_handles[$urandom_range(issued_handles.size() - 1)];
        if (it.kind == ITEM_LOOKUP_FLIPPED) begin
            h = h ^ (HANDLE_W'(1) << $urandom_range(HANDLE_W - 1));
        end
        return h;
    endfunction

    // Input driver. On an accepted transfer the predictor runs on the payload
    // that was on the bus, then the next queued item is offered unless the
    // sender idles this cycle. A waiting item is held until it is taken.
    always @(posedge aclk) begin : drive_items
        pending_item_t it;
        bit            take_next;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            take_next = !s_valid;
            if (s_valid && s_ready) begin
                expected_replies.push_back(
                    resolve_item(s_func, s_context_id, s_lookup_handle));
                take_next = 1'b1;
            end
            if (take_next) begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    it = pending_items.pop_front();
                    s_valid         <= 1'b1;
                    s_func          <= (it.kind == ITEM_REGISTER) ? FUNC_REGISTER : FUNC_LOOKUP;
                    s_context_id    <= it.ctx;
                    s_lookup_handle <= (it.kind == ITEM_REGISTER) ? it.look : lookup_target(it);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Counts down the long hold-off. While it runs the receiver stays not
    // ready, the output register fills and the block stops taking input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left    <= 0;
            hold_started <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_started) begin
            hold_left    <= 300;
            hold_started <= 1'b1;
        end
    end

    // Result monitor. Every accepted result transfer is checked field by
    // field against the oldest expected reply.
    always @(posedge aclk) begin : check_replies
        table_reply_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_replies.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result transfer, got handle %h context %h status %0d",
                             $time, m_result_handle, m_result_context, m_status);
                end else begin
                    want = expected_replies.pop_front();
                    if (m_result_handle !== want.handle || m_result_context !== want.ctx
                        || m_status !== want.status) begin
                        fail_count++;
                        $display("%0t: result mismatch, expected handle %h context %h status %0d,",
                                 $time, want.handle, want.ctx, want.status);
                        $display("%0t:   got handle %h context %h status %0d",
                                 $time, m_result_handle, m_result_context, m_status);
                    end
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic push_item(input item_kind_t kind, input logic [CTX_W-1:0] ctx,
                             input logic [HANDLE_W-1:0] look);
        pending_item_t it;
        it.kind = kind;
        it.ctx  = ctx;
        it.look = look;
        pending_items.push_back(it);
    endtask

    // Random items: registrations with random context, lookups of issued
    // handles, lookups of issued handles with one bit flipped, and lookups of
    // fully random handles. Fields that an operation ignores carry noise.
    task automatic fill_random(input int unsigned count);
        int unsigned roll;
        @(negedge aclk);
        for (int unsigned n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 28) begin
                push_item(ITEM_REGISTER, CTX_W'($urandom), $urandom);
            end else if (roll < 58) begin
                push_item(ITEM_LOOKUP_ISSUED, CTX_W'($urandom), $urandom);
            end else if (roll < 80) begin
                push_item(ITEM_LOOKUP_FLIPPED, CTX_W'($urandom), $urandom);
            end else begin
                push_item(ITEM_LOOKUP_FIXED, CTX_W'($urandom), $urandom);
            end
        end
    endtask

    // Waits at falling edges, where all handshake state has settled, until
    // no item is queued or offered and every expected reply has arrived.
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_replies.size() != 0);
        repeat (20) @(negedge aclk);
    endtask

    // Writes the node number through the configuration channel and mirrors
    // it in the predictor once the transfer has taken place.
    task automatic write_harbor(input logic [HARBOR_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        node_number = value;
    endtask

    task automatic set_rates(input int unsigned send_pct, input int unsigned recv_pct);
        @(negedge aclk);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items at the reset node number: misses on an empty table,
        // the context extremes, the first doubling and harbor mismatches.
        @(negedge aclk);
        push_item(ITEM_LOOKUP_FIXED, 16'hFFFF, 32'h0000_0000);
        push_item(ITEM_LOOKUP_FIXED, 16'h0000, 32'hFFFF_FFFF);
        push_item(ITEM_REGISTER, 16'h0000, 32'hFFFF_FFFF);
        push_item(ITEM_REGISTER, 16'hFFFF, 32'h0000_0000);
        push_item(ITEM_LOOKUP_ISSUED, 16'h0000, 32'h0);
        push_item(ITEM_REGISTER, 16'h1234, 32'h5A5A_A5A5);
        push_item(ITEM_REGISTER, 16'h00FF, 32'hA5A5_5A5A);
        push_item(ITEM_REGISTER, 16'h8000, 32'h0);
        push_item(ITEM_LOOKUP_FIXED, 16'h0, 32'h0000_0004);
        push_item(ITEM_LOOKUP_FIXED, 16'h0, 32'h0100_0004);
        push_item(ITEM_LOOKUP_FLIPPED, 16'h0, 32'h0);
        push_item(ITEM_LOOKUP_FLIPPED, 16'h0, 32'h0);
        for (int n = 0; n < 4; n++) begin
            push_item(ITEM_REGISTER, CTX_W'($urandom), $urandom);
        end
        wait_drained();

        // Directed items with every node number bit set.
        write_harbor(8'hFF);
        @(negedge aclk);
        for (int n = 0; n < 3; n++) begin
            push_item(ITEM_REGISTER, CTX_W'($urandom), $urandom);
        end
        push_item(ITEM_LOOKUP_FIXED, 16'h0, 32'hFF00_0009);
        push_item(ITEM_LOOKUP_FIXED, 16'h0, 32'h0000_0009);
        push_item(ITEM_LOOKUP_ISSUED, 16'h0, 32'h0);
        push_item(ITEM_LOOKUP_ISSUED, 16'h0, 32'h0);
        push_item(ITEM_LOOKUP_FLIPPED, 16'h0, 32'h0);
        wait_drained();

        // Random phases. The table reaches its largest size partway through
        // and later registrations report it full.
        write_harbor(8'h00);
        set_rates(0, 0);
        fill_random(300);
        wait_drained();

        write_harbor(HARBOR_W'($urandom));
        set_rates(56, 0);
        fill_random(300);
        wait_drained();

        // The long hold-off starts with this phase while the sender keeps
        // offering items.
        write_harbor(HARBOR_W'($urandom));
        set_rates(0, 56);
        hold_request = 1'b1;
        fill_random(300);
        wait_drained();

        write_harbor(8'hFF);
        set_rates(15, 15);
        fill_random(300);
        wait_drained();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
